### rtl/jsu_pkg.sv
// Types and codes shared by the JSON string unescaper modules.
package jsu_pkg;

    localparam int MAX_RES = 5;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_STR     = 4'd1,
        MODE_ESC     = 4'd2,
        MODE_HEX     = 4'd3,
        MODE_SURR_BS = 4'd4,
        MODE_SURR_U  = 4'd5,
        MODE_LOW_HEX = 4'd6,
        MODE_STOP    = 4'd7
    } mode_t;

    typedef enum logic [3:0] {
        ST_DATA         = 4'd0,
        ST_DONE         = 4'd1,
        ST_UNTERMINATED = 4'd2,
        ST_CONTROL      = 4'd3,
        ST_BAD_ESCAPE   = 4'd4,
        ST_BAD_HEX      = 4'd5,
        ST_NO_LOW       = 4'd6,
        ST_LONE_LOW     = 4'd7,
        ST_NO_QUOTE     = 4'd8
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] hex_accum;
        logic [1:0]  hex_count;
        logic [9:0]  high_half;
    } dec_state_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]       count;
        logic [MAX_RES-1:0][7:0]    data;
        status_t [MAX_RES-1:0]      status;
    } res_set_t;

endpackage

### rtl/jsu_decode.sv
// Per-byte decode: next decoder state and the list of results for one input byte.
module jsu_decode
    import jsu_pkg::*;
(
    input  dec_state_t state,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output dec_state_t state_next,
    output res_set_t   results
);

    logic        digit_ok;
    logic [3:0]  digit;
    logic [15:0] acc;
    logic [20:0] cp;
    logic        emit_cp;
    logic        emit_raw;
    logic [7:0]  raw_byte;
    logic        term;
    status_t     term_status;
    logic [2:0]  data_n;
    logic [3:0][7:0] data_bytes;

    always_comb
    begin
        digit_ok = 1'b1;
        digit    = 4'd0;
        if (in_byte inside {["0":"9"]})
            digit = in_byte[3:0];
        else if (in_byte inside {["a":"f"], ["A":"F"]})
            digit = in_byte[3:0] + 4'd9;
        else
            digit_ok = 1'b0;
    end

    assign acc = {state.hex_accum[11:0], digit};

    always_comb
    begin
        state_next  = state;
        cp          = 21'd0;
        emit_cp     = 1'b0;
        emit_raw    = 1'b0;
        raw_byte    = 8'd0;
        term        = 1'b0;
        term_status = ST_DATA;

        case (state.mode)
            MODE_IDLE:
            begin
                if (in_byte == "\"")
                    state_next.mode = MODE_STR;
                else
                begin
                    term        = 1'b1;
                    term_status = ST_NO_QUOTE;
                end
            end
            MODE_STR:
            begin
                if (in_byte == "\"")
                begin
                    term        = 1'b1;
                    term_status = ST_DONE;
                end
                else if (in_byte == "\\")
                    state_next.mode = MODE_ESC;
                else if (in_byte < 8'h20)
                begin
                    term        = 1'b1;
                    term_status = ST_CONTROL;
                end
                else
                begin
                    emit_raw = 1'b1;
                    raw_byte = in_byte;
                end
            end
            MODE_ESC:
            begin
                emit_raw = 1'b1;
                case (in_byte)
                    "\"": raw_byte = 8'h22;
                    "\\": raw_byte = 8'h5C;
                    "/":  raw_byte = 8'h2F;
                    "n":  raw_byte = 8'h0A;
                    "t":  raw_byte = 8'h09;
                    "r":  raw_byte = 8'h0D;
                    "b":  raw_byte = 8'h08;
                    "f":  raw_byte = 8'h0C;
                    "u":
                    begin
                        emit_raw             = 1'b0;
                        state_next.mode      = MODE_HEX;
                        state_next.hex_accum = 16'd0;
                        state_next.hex_count = 2'd0;
                    end
                    default:
                    begin
                        emit_raw    = 1'b0;
                        term        = 1'b1;
                        term_status = ST_BAD_ESCAPE;
                    end
                endcase
                if (emit_raw)
                    state_next.mode = MODE_STR;
            end
            MODE_HEX, MODE_LOW_HEX:
            begin
                if (!digit_ok)
                begin
                    term        = 1'b1;
                    term_status = (state.mode == MODE_HEX) ? ST_BAD_HEX : ST_NO_LOW;
                end
                else
                begin
                    state_next.hex_accum = acc;
                    if (state.hex_count != 2'd3)
                        state_next.hex_count = state.hex_count + 2'd1;
                    else
                    begin
                        state_next.hex_count = 2'd0;
                        if (state.mode == MODE_HEX)
                        begin
                            if (acc inside {[16'hD800:16'hDBFF]})
                            begin
                                state_next.high_half = acc[9:0];
                                state_next.mode      = MODE_SURR_BS;
                            end
                            else if (acc inside {[16'hDC00:16'hDFFF]})
                            begin
                                term        = 1'b1;
                                term_status = ST_LONE_LOW;
                            end
                            else
                            begin
                                emit_cp         = 1'b1;
                                cp              = {5'd0, acc};
                                state_next.mode = MODE_STR;
                            end
                        end
                        else if (acc inside {[16'hDC00:16'hDFFF]})
                        begin
                            emit_cp         = 1'b1;
                            cp              = 21'h10000 + {1'b0, state.high_half, acc[9:0]};
                            state_next.mode = MODE_STR;
                        end
                        else
                        begin
                            term        = 1'b1;
                            term_status = ST_NO_LOW;
                        end
                    end
                end
            end
            MODE_SURR_BS:
            begin
                if (in_byte == "\\")
                    state_next.mode = MODE_SURR_U;
                else
                begin
                    term        = 1'b1;
                    term_status = ST_NO_LOW;
                end
            end
            MODE_SURR_U:
            begin
                if (in_byte == "u")
                begin
                    state_next.mode      = MODE_LOW_HEX;
                    state_next.hex_accum = 16'd0;
                    state_next.hex_count = 2'd0;
                end
                else
                begin
                    term        = 1'b1;
                    term_status = ST_NO_LOW;
                end
            end
            default:
                state_next.mode = MODE_STOP;
        endcase

        // Errors and the closing quote stop the block; otherwise end of input
        // closes an open string with a status that depends on where it stopped.
        if (term)
            state_next.mode = MODE_STOP;
        else if (end_of_input && state_next.mode != MODE_STOP)
        begin
            term = 1'b1;
            if (state_next.mode == MODE_HEX)
                term_status = ST_BAD_HEX;
            else if (state_next.mode == MODE_SURR_BS || state_next.mode == MODE_SURR_U ||
                     state_next.mode == MODE_LOW_HEX)
                term_status = ST_NO_LOW;
            else
                term_status = ST_UNTERMINATED;
            state_next.mode = MODE_STOP;
        end
    end

    // UTF-8 encode
    always_comb
    begin
        data_n     = 3'd0;
        data_bytes = '0;
        if (emit_raw)
        begin
            data_n        = 3'd1;
            data_bytes[0] = raw_byte;
        end
        else if (emit_cp)
        begin
            if (cp < 21'h80)
            begin
                data_n        = 3'd1;
                data_bytes[0] = cp[7:0];
            end
            else if (cp < 21'h800)
            begin
                data_n        = 3'd2;
                data_bytes[0] = {3'b110, cp[10:6]};
                data_bytes[1] = {2'b10, cp[5:0]};
            end
            else if (cp < 21'h10000)
            begin
                data_n        = 3'd3;
                data_bytes[0] = {4'b1110, cp[15:12]};
                data_bytes[1] = {2'b10, cp[11:6]};
                data_bytes[2] = {2'b10, cp[5:0]};
            end
            else
            begin
                data_n        = 3'd4;
                data_bytes[0] = {5'b11110, cp[20:18]};
                data_bytes[1] = {2'b10, cp[17:12]};
                data_bytes[2] = {2'b10, cp[11:6]};
                data_bytes[3] = {2'b10, cp[5:0]};
            end
        end
    end

    always_comb
    begin
        results.count = RES_CNT_W'(data_n) + RES_CNT_W'(term);
        for (int i = 0; i < MAX_RES; i++)
        begin
            results.data[i]   = 8'd0;
            results.status[i] = ST_DATA;
            if (i < 4 && 3'(i) < data_n)
                results.data[i] = data_bytes[i[1:0]];
            else if (3'(i) == data_n)
                results.status[i] = term_status;
        end
    end

endmodule

### rtl/json_string_unescape.sv
// JSON string unescaper top level: input register, decode, result buffer.
// A byte's results pass through the input register and then the result buffer.
// Throughput: one input byte per cycle while each byte gives at most one result
// and m_tready is high; a byte giving more results (up to five) holds the next byte
// until the single result buffer, draining one result per cycle while m_tready is high, has sent them.
// Reset: rst_n clears the decoder to await the opening quote and empties both stages.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [3:0] status
    output logic       m_tlast    // last_of_run
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    dec_state_t           state_reg;
    dec_state_t           state_next;
    res_set_t             res_next;
    res_set_t             res_reg;
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 buf_free;
    logic                 load;
    logic                 s_xfer;
    logic                 m_xfer;
    logic                 last_one;

    jsu_decode u_decode (
        .state        (state_reg),
        .in_byte      (in_byte_reg),
        .end_of_input (in_last_reg),
        .state_next   (state_next),
        .results      (res_next)
    );

    assign m_tvalid = (idx_reg != cnt_reg);
    assign last_one = (idx_reg + RES_CNT_W'(1) == cnt_reg);
    assign m_xfer   = m_tvalid && m_tready;
    assign buf_free = !m_tvalid || (m_tready && last_one);
    assign load     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || load;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb
    begin
        m_tdata = 8'd0;
        m_tuser = ST_DATA;
        m_tlast = 1'b0;
        if (m_tvalid)
        begin
            m_tdata = res_reg.data[idx_reg];
            m_tuser = res_reg.status[idx_reg];
            m_tlast = last_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            cnt_reg             <= '0;
            idx_reg             <= '0;
            state_reg.mode      <= MODE_IDLE;
            state_reg.hex_accum <= 16'd0;
            state_reg.hex_count <= 2'd0;
            state_reg.high_half <= 10'd0;
        end
        else
        begin
            if (s_xfer)
                in_valid_reg <= 1'b1;
            else if (load)
                in_valid_reg <= 1'b0;

            // Advance the decoder and refill the result buffer as one step.
            if (load)
            begin
                state_reg <= state_next;
                cnt_reg   <= res_next.count;
                idx_reg   <= '0;
            end
            else if (m_xfer)
                idx_reg <= idx_reg + RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (load)
            res_reg <= res_next;
    end

endmodule
